[sv/segmented_ring_buffer_top_macros.svh]
// Assertion macros for the segmented ring buffer; clk and rst_n are taken from the using scope.
`ifndef SEGMENTED_RING_BUFFER_TOP_MACROS_SVH
`define SEGMENTED_RING_BUFFER_TOP_MACROS_SVH

// Check the consequent in the same cycle as the antecedent.
`define SRB_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check the consequent in the cycle after the antecedent.
`define SRB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/srb_pkg.sv]
package srb_pkg;

    localparam int REQ_W   = 3;
    localparam int DATA_W  = 16;
    localparam int POS_W   = 12;
    localparam int STAT_W  = 2;
    localparam int FILL_W  = 13;
    localparam int VPS_W   = 9;
    localparam int SEG_W   = 5;
    localparam int CAP_W   = VPS_W + SEG_W;
    localparam int CFG_W   = VPS_W;
    localparam int CFG_IDX_W = 1;

    localparam logic [VPS_W-1:0] VPS_RESET = 9'd256;
    localparam logic [SEG_W-1:0] SEG_RESET = 5'd16;

    typedef enum logic [REQ_W-1:0] {
        REQ_PUT    = 3'd0,
        REQ_GET    = 3'd1,
        REQ_UNGET  = 3'd2,
        REQ_ROTATE = 3'd3,
        REQ_READ   = 3'd4
    } req_e_t;

    typedef enum logic [STAT_W-1:0] {
        STS_OK          = 2'd0,
        STS_UNDER       = 2'd1,
        STS_OVER        = 2'd2,
        STS_UNGET_EMPTY = 2'd3
    } status_e_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_VPS = 1'b0,
        CFG_SEG = 1'b1
    } cfg_idx_e_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } state_t;

    typedef struct packed {
        logic capture;
        logic commit;
    } cmd_t;

endpackage

[sv/srb_if.sv]
interface srb_req_if import srb_pkg::*;;
    logic              valid;
    logic              ready;
    logic [REQ_W-1:0]  req_type;
    logic [DATA_W-1:0] write_value;
    logic [POS_W-1:0]  position;

    modport source (output valid, output req_type, output write_value, output position,
                    input ready);
    modport sink   (input valid, input req_type, input write_value, input position,
                    output ready);
endinterface

interface srb_rsp_if import srb_pkg::*;;
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] read_data;
    logic [STAT_W-1:0] status;
    logic [FILL_W-1:0] fill_level;

    modport source (output valid, output read_data, output status, output fill_level,
                    input ready);
    modport sink   (input valid, input read_data, input status, input fill_level,
                    output ready);
endinterface

[sv/srb_ctrl.sv]
module srb_ctrl import srb_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    output logic rsp_valid,
    input  logic rsp_ready,
    output cmd_t cmd
);

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || rsp_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req_ready      = 1'b0;
        cmd.capture    = 1'b0;
        cmd.commit     = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                req_ready   = 1'b1;
                cmd.capture = req_valid;
            end
            ST_EXEC:
            begin
                cmd.commit = out_free;
            end
            default:
            begin
                req_ready = 1'b0;
            end
        endcase
        out_valid_next = cmd.commit || (out_valid_reg && !rsp_ready);
    end

    assign rsp_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

[sv/srb_datapath.sv]
module srb_datapath import srb_pkg::*;
#(
    parameter int MAX_SEGMENTS       = 16,
    parameter int MAX_SEGMENT_VALUES = 256
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  cmd_t                 cmd,
    input  logic [REQ_W-1:0]     req_type,
    input  logic [DATA_W-1:0]    write_value,
    input  logic [POS_W-1:0]     position,
    output logic [DATA_W-1:0]    read_data,
    output logic [STAT_W-1:0]    status,
    output logic [FILL_W-1:0]    fill_level
);

    localparam int DEPTH = MAX_SEGMENTS * MAX_SEGMENT_VALUES;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int CMPW  = (CW > CAP_W) ? CW : CAP_W;

    logic [DATA_W-1:0] mem [DEPTH];

    logic [VPS_W-1:0]  vps_reg;
    logic [SEG_W-1:0]  seg_reg;
    logic [AW-1:0]     head_reg;
    logic [AW-1:0]     head_next;
    logic [AW-1:0]     tail_reg;
    logic [AW-1:0]     tail_next;
    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     count_next;
    logic [CW-1:0]     hw_reg;
    logic [CW-1:0]     hw_next;

    logic [REQ_W-1:0]  req_type_reg;
    logic [DATA_W-1:0] wv_reg;
    logic [POS_W-1:0]  pos_reg;
    logic [AW-1:0]     addr_reg;
    logic [DATA_W-1:0] rdata_reg;
    logic [DATA_W-1:0] read_data_reg;
    logic [STAT_W-1:0] status_reg;
    logic [FILL_W-1:0] fill_reg;

    logic [VPS_W-1:0]  vps_eff;
    logic [SEG_W-1:0]  seg_eff;
    logic [CAP_W-1:0]  cap_prod;
    logic [CMPW-1:0]   cap;
    logic [CMPW-1:0]   head_x;
    logic [CMPW-1:0]   tail_x;
    logic [CMPW-1:0]   count_x;
    logic [CMPW-1:0]   hw_x;
    logic [CMPW-1:0]   addr_x;
    logic [CMPW-1:0]   pos_x;
    logic [CMPW-1:0]   head_p1;
    logic [CMPW-1:0]   tail_p1;
    logic [CMPW-1:0]   head_adv;
    logic [CMPW-1:0]   tail_adv;
    logic [CMPW-1:0]   head_dec;
    logic [CMPW-1:0]   hw_wr;
    logic [AW-1:0]     rd_addr;
    logic [DATA_W-1:0] stored;
    logic              full;
    logic              empty;
    logic              mem_we;
    logic [DATA_W-1:0] mem_wdata;
    logic [DATA_W-1:0] data_next;
    logic [STAT_W-1:0] status_next;

    always_comb
    begin
        if (vps_reg == '0)
        begin
            vps_eff = VPS_W'(1);
        end
        else if (32'(vps_reg) > 32'(MAX_SEGMENT_VALUES))
        begin
            vps_eff = VPS_W'(MAX_SEGMENT_VALUES);
        end
        else
        begin
            vps_eff = vps_reg;
        end

        if (seg_reg == '0)
        begin
            seg_eff = SEG_W'(1);
        end
        else if (32'(seg_reg) > 32'(MAX_SEGMENTS))
        begin
            seg_eff = SEG_W'(MAX_SEGMENTS);
        end
        else
        begin
            seg_eff = seg_reg;
        end
    end

    assign cap_prod = CAP_W'(vps_eff) * CAP_W'(seg_eff);
    assign cap      = CMPW'(cap_prod);

    assign head_x  = CMPW'(head_reg);
    assign tail_x  = CMPW'(tail_reg);
    assign count_x = CMPW'(count_reg);
    assign hw_x    = CMPW'(hw_reg);
    assign addr_x  = CMPW'(addr_reg);
    assign pos_x   = CMPW'(pos_reg);

    assign head_p1  = head_x + CMPW'(1);
    assign tail_p1  = tail_x + CMPW'(1);
    assign head_adv = (head_p1 >= cap) ? '0 : head_p1;
    assign tail_adv = (tail_p1 >= cap) ? '0 : tail_p1;
    assign head_dec = (head_x == '0) ? (cap - CMPW'(1)) : (head_x - CMPW'(1));
    assign hw_wr    = (head_p1 > hw_x) ? head_p1 : hw_x;

    assign full   = (count_x == cap);
    assign empty  = (count_reg == '0);
    assign stored = (addr_x < hw_x) ? rdata_reg : '0;

    assign rd_addr = (req_type == REQ_READ) ? AW'(CMPW'(position)) : tail_reg;

    always_comb
    begin
        head_next   = head_reg;
        tail_next   = tail_reg;
        count_next  = count_reg;
        hw_next     = hw_reg;
        mem_we      = 1'b0;
        mem_wdata   = wv_reg;
        data_next   = '0;
        status_next = STS_OK;
        unique case (req_type_reg)
            REQ_PUT:
            begin
                if (full)
                begin
                    status_next = STS_OVER;
                end
                else
                begin
                    mem_we     = 1'b1;
                    head_next  = AW'(head_adv);
                    count_next = count_reg + CW'(1);
                    hw_next    = CW'(hw_wr);
                end
            end
            REQ_GET:
            begin
                if (empty)
                begin
                    status_next = STS_UNDER;
                end
                else
                begin
                    data_next  = stored;
                    tail_next  = AW'(tail_adv);
                    count_next = count_reg - CW'(1);
                end
            end
            REQ_UNGET:
            begin
                if (empty)
                begin
                    status_next = STS_UNGET_EMPTY;
                end
                else
                begin
                    head_next  = AW'(head_dec);
                    count_next = count_reg - CW'(1);
                end
            end
            REQ_ROTATE:
            begin
                if (empty)
                begin
                    status_next = STS_UNDER;
                end
                else
                begin
                    data_next = stored;
                    mem_we    = 1'b1;
                    mem_wdata = stored;
                    head_next = AW'(head_adv);
                    tail_next = AW'(tail_adv);
                    hw_next   = CW'(hw_wr);
                end
            end
            REQ_READ:
            begin
                if (empty)
                begin
                    status_next = STS_UNDER;
                end
                else if (pos_x >= cap)
                begin
                    status_next = STS_OVER;
                end
                else
                begin
                    data_next = stored;
                end
            end
            default:
            begin
                status_next = STS_OK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vps_reg   <= VPS_RESET;
            seg_reg   <= SEG_RESET;
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
            hw_reg    <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_VPS: vps_reg <= cfg_data;
                CFG_SEG: seg_reg <= SEG_W'(cfg_data);
                default: vps_reg <= vps_reg;
            endcase
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else if (cmd.commit)
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
            hw_reg    <= hw_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_type_reg <= req_type;
            wv_reg       <= write_value;
            pos_reg      <= position;
            addr_reg     <= rd_addr;
            rdata_reg    <= mem[rd_addr];
        end
        if (cmd.commit)
        begin
            if (mem_we)
            begin
                mem[head_reg] <= mem_wdata;
            end
            read_data_reg <= data_next;
            status_reg    <= status_next;
            fill_reg      <= FILL_W'(count_next);
        end
    end

    assign read_data  = read_data_reg;
    assign status     = status_reg;
    assign fill_level = fill_reg;

endmodule

[sv/segmented_ring_buffer_top.sv]
// Channel  | Role   | Payload
// ---------+--------+--------------------------------------
// req      | sink   | req_type, write_value, position
// rsp      | source | read_data, status, fill_level
// cfg      | write  | cfg_we, cfg_index, cfg_data
//
// Each request is captured, then committed: the memory read is registered before the commit.
// A request may be taken while the previous result waits on rsp.
// rst_n zeroes pointers and count; entries beyond the high-water mark read as zero.
// A stalled rsp holds the next request in the commit cycle until the output frees.
`include "segmented_ring_buffer_top_macros.svh"

module segmented_ring_buffer_top import srb_pkg::*;
#(
    parameter int MAX_SEGMENTS       = 16,
    parameter int MAX_SEGMENT_VALUES = 256
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    srb_req_if.sink              req,
    srb_rsp_if.source            rsp,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    cmd_t cmd;

    srb_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .cmd       (cmd)
    );

    srb_datapath
    #(
        .MAX_SEGMENTS       (MAX_SEGMENTS),
        .MAX_SEGMENT_VALUES (MAX_SEGMENT_VALUES)
    )
    u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .cmd         (cmd),
        .req_type    (req.req_type),
        .write_value (req.write_value),
        .position    (req.position),
        .read_data   (rsp.read_data),
        .status      (rsp.status),
        .fill_level  (rsp.fill_level)
    );

    `SRB_ASSERT_NEXT(a_one_in_flight, req.valid && req.ready, !req.ready, "request taken while busy")
    `SRB_ASSERT_NEXT(a_commit_shows, cmd.commit, rsp.valid, "committed result not shown")
    `SRB_ASSERT_SAME(a_empty_fill, rsp.valid && (rsp.status == STS_UNDER || rsp.status == STS_UNGET_EMPTY), rsp.fill_level == '0, "empty status with nonzero fill")

endmodule
